/* hdl/qpvf_pkg.sv */
// Shared constants for the URL query parameter lookup block.
`default_nettype none

package qpvf_pkg;

   // Key register geometry: the key register holds eight name bytes
   localparam int KEY_BYTES     = 8;
   localparam int KEY_W         = 8 * KEY_BYTES;
   localparam int KEY_LEN_W     = 4;

   // Default for the longest key the block compares
   localparam int DEF_MAX_KEY_BYTES = 8;

   // Query delimiters
   localparam logic [7:0] CH_AMP = 8'h26;
   localparam logic [7:0] CH_EQ  = 8'h3D;

   // Field widths
   localparam int OFFSET_W = 16;
   localparam int LENGTH_W = 16;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 1'd1;

endpackage : qpvf_pkg

`default_nettype wire

/* hdl/query_parameter_value_finder_unit.sv */
// Top level of the URL query parameter lookup block.
//
// Usage:
//   The request stream carries one query byte per transfer: tdata holds the
//   byte and the buffer offset of the query, tuser says whether the URL has a
//   query at all, and tlast marks the final query byte. The block looks for
//   the first parameter whose name equals the configured key followed by '='.
//   On the last byte (or at once for a URL without a query) one result goes
//   out on the response stream: tuser is the found flag, tdata the buffer
//   offset and length of the value, both zero when nothing was found.
//   The key name and its length are written over the csr channel while the
//   block is idle; csr_ready is always high.
// Timing:
//   A byte is first held in the input register, then the scan logic
//   updates the state and loads the response register. rsp_tvalid rises
//   once the last byte has passed the input register and the response
//   register (two register stages). One byte is accepted every cycle as
//   long as the response register is empty or drained.
// Reset and stall:
//   Reset clears the key, the scan state and both stage valids. While the
//   receiver holds rsp_tready low with a result pending, the input register
//   holds its byte and req_tready drops once that register is full.
`default_nettype none

module query_parameter_value_finder_unit
   import qpvf_pkg::*;
#(
   parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [23:0]            req_tdata,   // [7:0] query_byte, [23:8] query_offset
   input  wire logic                   req_tuser,   // [0] query_present
   input  wire logic                   req_tlast,   // last_byte
   // response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [31:0]                 rsp_tdata,   // [15:0] value_offset, [31:16] value_length
   output logic                        rsp_tuser,   // [0] found
   // configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [KEY_W-1:0]       csr_wdata
);

   localparam int NPW = $clog2(MAX_KEY_BYTES + 1);

   // configuration registers
   logic [KEY_W-1:0]      key_bytes_ff;
   logic [KEY_LEN_W-1:0]  key_length_ff;

   // input register
   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic [OFFSET_W-1:0]   in_offset_ff;
   logic                  in_present_ff;
   logic                  in_last_ff;

   // scan state
   logic [15:0]           byte_pos_ff,   byte_pos_in;
   logic [NPW-1:0]        name_pos_ff,   name_pos_in;
   logic                  at_start_ff,   at_start_in;
   logic                  name_ok_ff,    name_ok_in;
   logic                  match_ff,      match_in;
   logic                  in_value_ff,   in_value_in;
   logic [OFFSET_W-1:0]   found_off_ff,  found_off_in;
   logic [LENGTH_W-1:0]   found_len_ff,  found_len_in;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [OFFSET_W-1:0]   rsp_offset_ff;
   logic [LENGTH_W-1:0]   rsp_length_ff;

   logic                  advance;
   logic                  emit;
   logic                  clear;
   logic [NPW-1:0]        klen_eff;
   logic [7:0]            key_byte;
   logic [5:0]            pos_wide;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff  <= '0;
         key_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_BYTES:  key_bytes_ff  <= csr_wdata;
            CSR_KEY_LENGTH: key_length_ff <= csr_wdata[KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff    <= req_tdata[7:0];
         in_offset_ff  <= req_tdata[23:8];
         in_present_ff <= req_tuser;
         in_last_ff    <= req_tlast;
      end
   end

   // key length clamped to the compare depth
   always_comb begin
      if (32'(key_length_ff) > MAX_KEY_BYTES) begin
         klen_eff = NPW'(MAX_KEY_BYTES);
      end else begin
         klen_eff = NPW'(key_length_ff);
      end
   end

   // key byte at the current name position, zero past the key register
   assign pos_wide = 6'(name_pos_ff);
   always_comb begin
      key_byte = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (pos_wide == 6'(i)) begin
            key_byte = key_bytes_ff[8*i +: 8];
         end
      end
   end

   // scan step on the registered byte
   always_comb begin
      byte_pos_in  = byte_pos_ff + 16'd1;
      name_pos_in  = name_pos_ff;
      at_start_in  = at_start_ff;
      name_ok_in   = name_ok_ff;
      match_in     = match_ff;
      in_value_in  = in_value_ff;
      found_off_in = found_off_ff;
      found_len_in = found_len_ff;
      emit         = 1'b0;
      clear        = 1'b0;

      if (!in_present_ff) begin
         emit  = 1'b1;
         clear = 1'b1;
      end else begin
         if (match_ff) begin
            if (in_value_ff) begin
               if (in_byte_ff == CH_AMP) begin
                  in_value_in = 1'b0;
               end else if (found_len_ff != '1) begin
                  found_len_in = found_len_ff + 16'd1;
               end
            end
         end else if (in_byte_ff == CH_AMP) begin
            at_start_in = 1'b1;
         end else begin
            // a new parameter restarts the name compare at this byte
            if (at_start_ff || name_ok_ff) begin
               at_start_in = 1'b0;
               if (at_start_ff || name_pos_ff < klen_eff) begin
                  if ((at_start_ff ? (klen_eff != '0) : 1'b1)) begin
                     if (in_byte_ff == (at_start_ff ? key_bytes_ff[7:0] : key_byte)) begin
                        name_pos_in = at_start_ff ? NPW'(1) : name_pos_ff + NPW'(1);
                        name_ok_in  = 1'b1;
                     end else begin
                        name_pos_in = at_start_ff ? '0 : name_pos_ff;
                        name_ok_in  = 1'b0;
                     end
                  end else if (in_byte_ff == CH_EQ) begin
                     // empty key: a parameter that opens with '=' matches
                     name_pos_in  = '0;
                     name_ok_in   = 1'b1;
                     match_in     = 1'b1;
                     in_value_in  = 1'b1;
                     found_off_in = in_offset_ff + byte_pos_ff + 16'd1;
                     found_len_in = '0;
                  end else begin
                     name_pos_in = '0;
                     name_ok_in  = 1'b0;
                  end
               end else if (in_byte_ff == CH_EQ) begin
                  match_in     = 1'b1;
                  in_value_in  = 1'b1;
                  found_off_in = in_offset_ff + byte_pos_ff + 16'd1;
                  found_len_in = '0;
               end else begin
                  name_ok_in = 1'b0;
               end
            end
         end
         if (in_last_ff) begin
            emit  = 1'b1;
            clear = 1'b1;
         end
      end
   end

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset || (advance && clear)) begin
         byte_pos_ff  <= '0;
         name_pos_ff  <= '0;
         at_start_ff  <= 1'b1;
         name_ok_ff   <= 1'b0;
         match_ff     <= 1'b0;
         in_value_ff  <= 1'b0;
         found_off_ff <= '0;
         found_len_ff <= '0;
      end else if (advance) begin
         byte_pos_ff  <= byte_pos_in;
         name_pos_ff  <= name_pos_in;
         at_start_ff  <= at_start_in;
         name_ok_ff   <= name_ok_in;
         match_ff     <= match_in;
         in_value_ff  <= in_value_in;
         found_off_ff <= found_off_in;
         found_len_ff <= found_len_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_found_ff  <= in_present_ff && match_in;
         rsp_offset_ff <= (in_present_ff && match_in) ? found_off_in : '0;
         rsp_length_ff <= (in_present_ff && match_in) ? found_len_in : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {rsp_length_ff, rsp_offset_ff};

   // a not-found result carries zero offset and length
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_offset_ff == '0 && rsp_length_ff == '0))
      else $error("not-found result with nonzero fields");

   // value length only grows once a match is recorded
   a_len_needs_match: assert property (@(posedge clock) disable iff (reset)
      (!match_ff) |-> (found_len_ff == '0 && !in_value_ff))
      else $error("value length without a match");

   // name position never passes the clamped key length
   a_name_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (!at_start_ff && name_ok_ff) |-> (name_pos_ff <= klen_eff))
      else $error("name position past key length");

   // input stage only refuses a byte while holding one for a full response stage
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (!req_tready) |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a pending response");

endmodule : query_parameter_value_finder_unit

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the URL query parameter lookup block.
`default_nettype none

module tb;
   import qpvf_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int SEGMENT_ITEMS = 125;

   // One lookup outcome as it leaves the response stream
   typedef struct packed {
      logic        found;
      logic [15:0] offset;
      logic [15:0] length;
   } lookup_result_type;

   // Tracks the scan of the current query and holds the outcomes still due
   class query_lookup_scoreboard;
      logic [KEY_W-1:0]     key_name;
      logic [KEY_LEN_W-1:0] key_len;
      logic [15:0]          scan_pos;
      int unsigned          name_idx;
      bit                   at_param_start;
      bit                   name_ok;
      bit                   hit;
      bit                   in_val;
      logic [15:0]          hit_offset;
      logic [15:0]          hit_length;
      lookup_result_type    expected_q[$];
      int unsigned          errors;

      function new();
         key_name = '0;
         key_len  = '0;
         errors   = 0;
         restart_scan();
      endfunction

      function void restart_scan();
         scan_pos       = '0;
         name_idx       = 0;
         at_param_start = 1'b1;
         name_ok        = 1'b0;
         hit            = 1'b0;
         in_val         = 1'b0;
         hit_offset     = '0;
         hit_length     = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [KEY_W-1:0] value);
         if (idx == CSR_KEY_BYTES) key_name = value;
         else if (idx == CSR_KEY_LENGTH) key_len = value[KEY_LEN_W-1:0];
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Advance the scan by one accepted byte; queue an outcome where one is due
      function void note_request(logic [7:0] b, logic [15:0] off, bit present, bit last);
         int unsigned       klen;
         lookup_result_type r;
         r = '0;
         if (!present) begin
            expected_q.push_back(r);
            restart_scan();
            return;
         end
         klen = (key_len > DEF_MAX_KEY_BYTES) ? DEF_MAX_KEY_BYTES : key_len;
         if (hit) begin
            // value scan: stop at the next separator, length saturates
            if (in_val) begin
               if (b == CH_AMP) in_val = 1'b0;
               else if (hit_length != 16'hFFFF) hit_length++;
            end
         end else if (b == CH_AMP) begin
            at_param_start = 1'b1;
         end else begin
            if (at_param_start) begin
               name_idx       = 0;
               name_ok        = 1'b1;
               at_param_start = 1'b0;
            end
            if (name_ok) begin
               if (name_idx < klen) begin
                  if (b == key_name[8*name_idx +: 8]) name_idx++;
                  else name_ok = 1'b0;
               end else if (b == CH_EQ) begin
                  hit        = 1'b1;
                  in_val     = 1'b1;
                  hit_offset = off + scan_pos + 16'd1;
                  hit_length = '0;
               end else begin
                  name_ok = 1'b0;
               end
            end
         end
         scan_pos++;
         if (last) begin
            r.found  = hit;
            r.offset = hit ? hit_offset : 16'd0;
            r.length = hit ? hit_length : 16'd0;
            expected_q.push_back(r);
            restart_scan();
         end
      endfunction

      // Compare one response transfer against the oldest outcome due
      function void check_response(logic found, logic [15:0] off, logic [15:0] len);
         lookup_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response found=%0d offset=%0d length=%0d",
                     $time, found, off, len);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (e.found !== found) begin
            $display("%0t: found expected %0d, got %0d", $time, e.found, found);
            errors++;
         end
         if (e.offset !== off) begin
            $display("%0t: value_offset expected %0d, got %0d", $time, e.offset, off);
            errors++;
         end
         if (e.length !== len) begin
            $display("%0t: value_length expected %0d, got %0d", $time, e.length, len);
            errors++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata  = '0;   // [7:0] query_byte, [23:8] query_offset
   logic                   req_tuser  = 1'b0; // [0] query_present
   logic                   req_tlast  = 1'b0; // last_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;         // [15:0] value_offset, [31:16] value_length
   logic                   rsp_tuser;         // [0] found
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [KEY_W-1:0]       csr_wdata  = '0;

   query_lookup_scoreboard sb = new();

   logic [KEY_W-1:0]     key_now = '0;
   logic [KEY_LEN_W-1:0] len_now = '0;
   logic [7:0]           query_bytes[$];
   int unsigned          items_sent    = 0;
   int unsigned          send_idle_pct = 0;
   int unsigned          recv_idle_pct = 0;
   int unsigned          hold_left     = 0;
   int unsigned          stall_count   = 0;

   query_parameter_value_finder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Response side: check each transfer, stall at random or for a long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]);
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_count <= 0;
      else if (stall_count == STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else
         stall_count <= stall_count + 1;
   end

   // Offer one request item and wait for its transfer
   task automatic send_item(input logic [7:0] b, input logic [15:0] off,
                            input bit present, input bit last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {off, b};
      req_tuser  <= present;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(b, off, present, last);
      items_sent++;
   endtask

   // Key name and length, written back to back while the block is idle
   task automatic set_key(input logic [KEY_W-1:0] name, input logic [KEY_W-1:0] len_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_KEY_BYTES;
      csr_wdata <= name;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(CSR_KEY_BYTES, name);
      csr_index <= CSR_KEY_LENGTH;
      csr_wdata <= len_word;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(CSR_KEY_LENGTH, len_word);
      csr_valid <= 1'b0;
      key_now = name;
      len_now = len_word[KEY_LEN_W-1:0];
   endtask

   // Drop valid, wait for every outcome, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] noise_byte();
      int unsigned pos;
      pos = $urandom_range(0, KEY_BYTES - 1);
      case ($urandom_range(0, 4))
         0:       return CH_AMP;
         1:       return CH_EQ;
         2:       return key_now[8*pos +: 8];
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] alpha_key(input bit with_amp);
      logic [KEY_W-1:0] k;
      int unsigned      pos;
      for (int i = 0; i < KEY_BYTES; i++) begin
         case ($urandom_range(0, 3))
            0:       k[8*i +: 8] = "a";
            1:       k[8*i +: 8] = "b";
            2:       k[8*i +: 8] = "c";
            default: k[8*i +: 8] = 8'($urandom_range(0, 255));
         endcase
      end
      pos = $urandom_range(0, 4);
      if (with_amp) k[8*pos +: 8] = CH_AMP;
      return k;
   endfunction

   function automatic logic [15:0] pick_offset();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) query_bytes.push_back(s[i]);
   endtask

   // Query of parameters, most of the form name=value, names close to the key
   task automatic build_query();
      int unsigned n_params, elen, kind, cut, nlen, vlen;
      logic [7:0]  c;
      query_bytes.delete();
      elen = (len_now > DEF_MAX_KEY_BYTES) ? DEF_MAX_KEY_BYTES : len_now;
      n_params = $urandom_range(1, 4);
      for (int p = 0; p < n_params; p++) begin
         if (p > 0) query_bytes.push_back(CH_AMP);
         kind = $urandom_range(0, 5);
         case (kind)
            0, 1: for (int i = 0; i < elen; i++) query_bytes.push_back(key_now[8*i +: 8]);
            2: begin
               // truncated name
               cut = (elen == 0) ? 0 : $urandom_range(0, elen - 1);
               for (int i = 0; i < cut; i++) query_bytes.push_back(key_now[8*i +: 8]);
            end
            3: begin
               // one name byte corrupted
               cut = (elen == 0) ? 0 : $urandom_range(0, elen - 1);
               for (int i = 0; i < elen; i++) begin
                  c = key_now[8*i +: 8];
                  if (i == cut) c = c ^ 8'($urandom_range(1, 255));
                  query_bytes.push_back(c);
               end
               if (elen == 0) query_bytes.push_back(noise_byte());
            end
            4: begin
               // name one byte too long
               for (int i = 0; i < elen; i++) query_bytes.push_back(key_now[8*i +: 8]);
               query_bytes.push_back(noise_byte());
            end
            default: begin
               nlen = $urandom_range(0, 3);
               for (int i = 0; i < nlen; i++) query_bytes.push_back(noise_byte());
            end
         endcase
         if ($urandom_range(0, 4) != 0) query_bytes.push_back(CH_EQ);
         vlen = $urandom_range(0, 6);
         for (int i = 0; i < vlen; i++) query_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (query_bytes.size() == 0) query_bytes.push_back(noise_byte());
   endtask

   task automatic build_noise();
      int unsigned n;
      query_bytes.delete();
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) query_bytes.push_back(noise_byte());
   endtask

   // Send the built query, last marker on its final byte; may slip in no-query items
   task automatic send_query(input logic [15:0] off, input bit jitter, input bit inject);
      foreach (query_bytes[i]) begin
         if (inject && $urandom_range(0, 99) == 0)
            send_item(8'($urandom), 16'($urandom), 1'b0, 1'($urandom_range(0, 1)));
         send_item(query_bytes[i], jitter ? 16'($urandom) : off, 1'b1,
                   i == query_bytes.size() - 1);
      end
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 6) == 0) begin
            build_noise();
            send_query(pick_offset(), 1'($urandom_range(0, 1)), 1'b1);
         end else begin
            build_query();
            send_query(pick_offset(), 1'b0, 1'b1);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: key "ab"
      send_idle_pct = 12;
      recv_idle_pct = 60;
      set_key(64'h6261, 64'd2);
      send_item(8'hFF, 16'hFFFF, 1'b0, 1'b0);
      query_bytes.delete();
      put_text("ab=");
      query_bytes.push_back(8'h00);
      send_query(16'hFFFF, 1'b0, 1'b0);
      query_bytes.delete();
      put_text("ab=");
      send_query(16'h0000, 1'b0, 1'b0);
      query_bytes.delete();
      put_text("x&ab=");
      query_bytes.push_back(8'hFF);
      put_text("&ab=22");
      send_query(16'h0100, 1'b0, 1'b0);
      settle();

      // Directed: empty key matches a parameter that opens with '='
      set_key(64'h0, 64'd0);
      query_bytes.delete();
      put_text("=");
      send_query(16'h0042, 1'b0, 1'b0);
      query_bytes.delete();
      put_text("z=1");
      send_query(16'h0042, 1'b0, 1'b0);
      settle();

      // Directed: a key holding '&' never matches
      set_key(64'h2661, 64'd2);
      query_bytes.delete();
      put_text("a&=");
      send_query(16'h0010, 1'b0, 1'b0);
      settle();

      // Random segments, one key setting each
      set_key(alpha_key(1'b0), 64'd3);
      run_random(SEGMENT_ITEMS);
      settle();
      set_key({KEY_W{1'b1}}, 64'd15);
      run_random(SEGMENT_ITEMS);
      settle();

      send_idle_pct = 60;
      recv_idle_pct = 12;
      set_key(64'h0, 64'd0);
      run_random(SEGMENT_ITEMS);
      settle();
      set_key({$urandom, $urandom}, 64'd8);
      run_random(SEGMENT_ITEMS);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_key(alpha_key(1'b0), 64'd1);
      // long receiver hold-off so the block backs up into the request side
      hold_left <= 300;
      run_random(SEGMENT_ITEMS);
      settle();
      set_key(alpha_key(1'b1), 64'd5);
      run_random(SEGMENT_ITEMS);
      settle();

      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
